>>> rtl/core/thread_instruction_executor_unit_assert.svh
// Assertion macros for the thread instruction executor.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef THREAD_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define THREAD_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds.
`define TIEU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never occurs.
`define TIEU_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TIEU_ASSERT(label, clk, rst, prop, msg)
`define TIEU_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> rtl/core/tieu_pkg.sv
package tieu_pkg;

   // Register file and data memory geometry
   localparam int REG_IDX_W = 3;
   localparam int NUM_REGS  = 2 ** REG_IDX_W;
   localparam int MEM_IDX_W = 10;
   localparam int MEM_WORDS = 2 ** MEM_IDX_W;

   localparam int WORD_W    = 32;
   localparam int LAT_W     = 8;

   // Code line advance per executed instruction
   localparam logic [WORD_W-1:0] PC_STEP = 32'd32;

   // Request tdata layout, lowest bit first
   localparam int REQ_OPCODE_LSB = 0;
   localparam int REQ_DST_LSB    = 3;
   localparam int REQ_SRC1_LSB   = 6;
   localparam int REQ_IMM_LSB    = 9;
   localparam int REQ_ISIMM_LSB  = 41;
   localparam int REQ_PIDX_LSB   = 42;
   localparam int REQ_PDATA_LSB  = 52;
   localparam int REQ_TDATA_W    = 88;
   localparam int REQ_TUSER_W    = 2;

   // Response tdata layout, lowest bit first
   localparam int RSP_ACC_LSB    = 0;
   localparam int RSP_READY_LSB  = 1;
   localparam int RSP_HALT_LSB   = 2;
   localparam int RSP_PC_LSB     = 3;
   localparam int RSP_WR_LSB     = 35;
   localparam int RSP_VAL_LSB    = 36;
   localparam int RSP_USED_W     = 68;
   localparam int RSP_TDATA_W    = 72;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LATENCY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STORE_LATENCY = 1'b1;

   typedef enum logic [1:0] {
      CMD_EXEC    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_PRELOAD = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_ADDI  = 3'd3,
      OP_SUBI  = 3'd4,
      OP_LOAD  = 3'd5,
      OP_STORE = 3'd6,
      OP_HALT  = 3'd7
   } opcode_type;

endpackage

>>> rtl/core/thread_instruction_executor_unit.sv
// Thread instruction executor: runs one thread's instructions against an
// eight-entry register file and a 1024-word data memory.
// Request channel (req_*): one transaction per command. tuser carries the
// command (execute, tick, preload); tdata carries the instruction fields and
// the preload word. Response channel (rsp_*): exactly one transaction per
// request, in order, with accepted, ready, halted, next code line and the
// register write result.
// Configuration channel (csr_*): always ready; index 0 writes the load
// latency, index 1 the store latency. Write only while the unit is idle.
// Requests are taken one per cycle while the receiver does not stall. The
// register file is read as a request is taken; stage 1 executes it with the
// data memory access; stage 2 returns load data and writes the register as
// the result enters the output register. Forwarding from the pending and the
// last register write covers back-to-back dependencies.
// Reset clears the register file (through per-entry valid bits), the wait
// count, the halt flag, the code line and the latencies; the data memory is
// not cleared. When the receiver stalls, the whole pipeline holds and
// req_tready drops in the same cycle.
`include "thread_instruction_executor_unit_assert.svh"

module thread_instruction_executor_unit
   import tieu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // opcode, dst_reg, src1_reg, src2_or_imm, src2_is_imm,
   // preload_word_index, preload_word_data
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // cmd
   input  logic [REQ_TUSER_W-1:0]  req_tuser,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // accepted, ready_res, halted, code_line, reg_written, written_value
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [LAT_W-1:0]        csr_data
);

   // Pick the newest value of a register: pending write, last write, array, or zero if never written
   function automatic logic [WORD_W-1:0] fwd_sel(
      input logic [REG_IDX_W-1:0] addr,
      input logic [WORD_W-1:0]    ram_data,
      input logic                 ram_vld,
      input logic                 s2_en,
      input logic [REG_IDX_W-1:0] s2_addr,
      input logic [WORD_W-1:0]    s2_data,
      input logic                 lw_en,
      input logic [REG_IDX_W-1:0] lw_addr,
      input logic [WORD_W-1:0]    lw_data
   );
      logic [WORD_W-1:0] res;
      if (s2_en && (s2_addr == addr)) begin
         res = s2_data;
      end else if (lw_en && (lw_addr == addr)) begin
         res = lw_data;
      end else if (ram_vld) begin
         res = ram_data;
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // Pipeline advance and handshakes
   logic adv;
   logic acc_in;

   // Request fields
   logic [REG_IDX_W-1:0] in_dst;
   logic [REG_IDX_W-1:0] in_src1;
   logic [REG_IDX_W-1:0] in_src2;

   // Configuration
   logic [LAT_W-1:0] load_lat_ff;
   logic [LAT_W-1:0] store_lat_ff;

   // Register file: two copies so three operands read in one cycle
   logic [WORD_W-1:0]   rfa_mem [NUM_REGS];
   logic [WORD_W-1:0]   rfb_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic                rf_we;
   logic [REG_IDX_W-1:0] rf_waddr;
   logic [WORD_W-1:0]   rf_wdata;

   logic [WORD_W-1:0] rd_src1_ff;
   logic [WORD_W-1:0] rd_dst_ff;
   logic [WORD_W-1:0] rd_src2_ff;
   logic              rd_src1_vld_ff;
   logic              rd_dst_vld_ff;
   logic              rd_src2_vld_ff;

   // Last register write, for the operand read that just missed it
   logic                 lw_valid_ff;
   logic [REG_IDX_W-1:0] lw_addr_ff;
   logic [WORD_W-1:0]    lw_data_ff;

   // Data memory
   logic [WORD_W-1:0]    dmem [MEM_WORDS];
   logic [WORD_W-1:0]    mem_rdata_ff;
   logic                 mem_we;
   logic                 mem_re;
   logic [MEM_IDX_W-1:0] mem_addr_in;
   logic [WORD_W-1:0]    mem_wdata_in;

   // Stage 1: execute
   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;
   opcode_type            s1_op_ff;
   logic [REG_IDX_W-1:0]  s1_dst_ff;
   logic [REG_IDX_W-1:0]  s1_src1_ff;
   logic [REG_IDX_W-1:0]  s1_src2_ff;
   logic [WORD_W-1:0]     s1_imm_ff;
   logic                  s1_isimm_ff;
   logic [MEM_IDX_W-1:0]  s1_pidx_ff;
   logic [WORD_W-1:0]     s1_pdata_ff;

   // Thread state
   logic               halt_ff;
   logic               halt_in;
   logic [LAT_W-1:0]   wait_ff;
   logic [LAT_W-1:0]   wait_in;
   logic [WORD_W-1:0]  pc_ff;
   logic [WORD_W-1:0]  pc_in;

   // Execute results
   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;
   logic [WORD_W-1:0] op_d;
   logic [WORD_W-1:0] second;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] addr_sum;
   logic [WORD_W-1:0] alu_in;
   logic              ready_now;
   logic              exec;
   logic              wr_in;
   logic              is_load;
   logic              is_store;
   logic              is_preload;
   logic              ready_res_in;

   // Stage 2: load return and register write
   logic                 s2_valid_ff;
   logic                 s2_acc_ff;
   logic                 s2_ready_ff;
   logic                 s2_halt_ff;
   logic [WORD_W-1:0]    s2_pc_ff;
   logic                 s2_wr_ff;
   logic                 s2_load_ff;
   logic [WORD_W-1:0]    s2_alu_ff;
   logic [REG_IDX_W-1:0] s2_dst_ff;
   logic [WORD_W-1:0]    s2_val;

   // Output register
   logic              rsp_valid_ff;
   logic              rsp_acc_ff;
   logic              rsp_ready_ff;
   logic              rsp_halt_ff;
   logic [WORD_W-1:0] rsp_pc_ff;
   logic              rsp_wr_ff;
   logic [WORD_W-1:0] rsp_val_ff;

   // Advance whenever the output register is free or being taken
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign acc_in     = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   assign in_dst  = req_tdata[REQ_DST_LSB +: REG_IDX_W];
   assign in_src1 = req_tdata[REQ_SRC1_LSB +: REG_IDX_W];
   assign in_src2 = req_tdata[REQ_IMM_LSB +: REG_IDX_W];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         load_lat_ff  <= '0;
         store_lat_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOAD_LATENCY:  load_lat_ff  <= csr_data;
            CSR_STORE_LATENCY: store_lat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Register file arrays: write from stage 2, read at request acceptance
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rfa_mem[rf_waddr] <= rf_wdata;
         rfb_mem[rf_waddr] <= rf_wdata;
      end
      if (acc_in) begin
         rd_src1_ff <= rfa_mem[in_src1];
         rd_dst_ff  <= rfa_mem[in_dst];
         rd_src2_ff <= rfb_mem[in_src2];
      end
   end

   // Valid bits stand in for the register file reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_in) begin
         rd_src1_vld_ff <= rf_valid_ff[in_src1];
         rd_dst_vld_ff  <= rf_valid_ff[in_dst];
         rd_src2_vld_ff <= rf_valid_ff[in_src2];
      end
   end

   // Track the most recent register write
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (adv) begin
         lw_valid_ff <= rf_we;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         lw_addr_ff <= rf_waddr;
         lw_data_ff <= rf_wdata;
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_in) begin
         s1_cmd_ff   <= cmd_type'(req_tuser);
         s1_op_ff    <= opcode_type'(req_tdata[REQ_OPCODE_LSB +: 3]);
         s1_dst_ff   <= in_dst;
         s1_src1_ff  <= in_src1;
         s1_src2_ff  <= in_src2;
         s1_imm_ff   <= req_tdata[REQ_IMM_LSB +: WORD_W];
         s1_isimm_ff <= req_tdata[REQ_ISIMM_LSB];
         s1_pidx_ff  <= req_tdata[REQ_PIDX_LSB +: MEM_IDX_W];
         s1_pdata_ff <= req_tdata[REQ_PDATA_LSB +: WORD_W];
      end
   end

   // Stage 2 write value: load data straight from the memory output
   assign s2_val = s2_load_ff ? mem_rdata_ff : s2_alu_ff;

   // Register write leaves with the transaction that moves to the output
   assign rf_we    = adv && s2_valid_ff && s2_wr_ff;
   assign rf_waddr = s2_dst_ff;
   assign rf_wdata = s2_val;

   // Forward operands
   always_comb begin
      op_a = fwd_sel(s1_src1_ff, rd_src1_ff, rd_src1_vld_ff, s2_valid_ff && s2_wr_ff,
                     s2_dst_ff, s2_val, lw_valid_ff, lw_addr_ff, lw_data_ff);
      op_b = fwd_sel(s1_src2_ff, rd_src2_ff, rd_src2_vld_ff, s2_valid_ff && s2_wr_ff,
                     s2_dst_ff, s2_val, lw_valid_ff, lw_addr_ff, lw_data_ff);
      op_d = fwd_sel(s1_dst_ff, rd_dst_ff, rd_dst_vld_ff, s2_valid_ff && s2_wr_ff,
                     s2_dst_ff, s2_val, lw_valid_ff, lw_addr_ff, lw_data_ff);
   end

   // Execute: decode, ALU, address, thread state
   always_comb begin
      ready_now  = !halt_ff && (wait_ff == '0);
      exec       = 1'b0;
      second     = s1_isimm_ff ? s1_imm_ff : op_b;
      base       = (s1_op_ff == OP_STORE) ? op_d : op_a;
      addr_sum   = base + second;
      alu_in     = '0;
      wr_in      = 1'b0;
      is_load    = 1'b0;
      is_store   = 1'b0;
      is_preload = 1'b0;
      halt_in    = halt_ff;
      wait_in    = wait_ff;
      pc_in      = pc_ff;
      case (s1_cmd_ff)
         CMD_EXEC: begin
            if (ready_now) begin
               exec  = 1'b1;
               pc_in = pc_ff + PC_STEP;
               case (s1_op_ff)
                  OP_ADD: begin
                     alu_in = op_a + op_b;
                     wr_in  = 1'b1;
                  end
                  OP_SUB: begin
                     alu_in = op_a - op_b;
                     wr_in  = 1'b1;
                  end
                  OP_ADDI: begin
                     alu_in = op_a + s1_imm_ff;
                     wr_in  = 1'b1;
                  end
                  OP_SUBI: begin
                     alu_in = op_a - s1_imm_ff;
                     wr_in  = 1'b1;
                  end
                  OP_LOAD: begin
                     is_load = 1'b1;
                     wr_in   = 1'b1;
                     wait_in = load_lat_ff;
                  end
                  OP_STORE: begin
                     is_store = 1'b1;
                     wait_in  = store_lat_ff;
                  end
                  OP_HALT: halt_in = 1'b1;
                  default: ;
               endcase
            end
         end
         CMD_TICK: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end
         end
         CMD_PRELOAD: is_preload = 1'b1;
         default: ;
      endcase
      ready_res_in = !halt_in && (wait_in == '0);
   end

   // Memory port controls
   assign mem_we       = adv && s1_valid_ff && (is_store || is_preload);
   assign mem_re       = adv && s1_valid_ff && is_load;
   assign mem_addr_in  = is_preload ? s1_pidx_ff : addr_sum[MEM_IDX_W+1:2];
   assign mem_wdata_in = is_preload ? s1_pdata_ff : op_a;

   // Data memory: one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dmem[mem_addr_in] <= mem_wdata_in;
      end
      if (mem_re) begin
         mem_rdata_ff <= dmem[mem_addr_in];
      end
   end

   // Thread state update
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff <= 1'b0;
         wait_ff <= '0;
         pc_ff   <= '0;
      end else if (adv && s1_valid_ff) begin
         halt_ff <= halt_in;
         wait_ff <= wait_in;
         pc_ff   <= pc_in;
      end
   end

   // Stage 2 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         s2_acc_ff   <= exec;
         s2_ready_ff <= ready_res_in;
         s2_halt_ff  <= halt_in;
         s2_pc_ff    <= pc_in;
         s2_wr_ff    <= wr_in;
         s2_load_ff  <= is_load;
         s2_alu_ff   <= alu_in;
         s2_dst_ff   <= s1_dst_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         rsp_acc_ff   <= s2_acc_ff;
         rsp_ready_ff <= s2_ready_ff;
         rsp_halt_ff  <= s2_halt_ff;
         rsp_pc_ff    <= s2_pc_ff;
         rsp_wr_ff    <= s2_wr_ff;
         rsp_val_ff   <= s2_wr_ff ? s2_val : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, rsp_val_ff, rsp_wr_ff, rsp_pc_ff,
                        rsp_halt_ff, rsp_ready_ff, rsp_acc_ff};

   // Checks
   `TIEU_ASSERT(a_wr_needs_acc, clock, reset, rsp_valid_ff && rsp_wr_ff |-> rsp_acc_ff, "register write reported without an executed instruction")
   `TIEU_ASSERT(a_halt_sticky, clock, reset, halt_ff |=> halt_ff, "halt flag cleared without reset")
   `TIEU_ASSERT(a_tick_decrements, clock, reset, adv && s1_valid_ff && (s1_cmd_ff == CMD_TICK) && (wait_ff != '0) |=> wait_ff == $past(wait_ff) - 1'b1, "tick did not count the wait down")
   `TIEU_ASSERT_NEVER(a_mem_one_access, clock, reset, mem_we && mem_re, "data memory read and written in one cycle")
   `TIEU_ASSERT(a_rf_valid_set, clock, reset, rf_we |=> rf_valid_ff[lw_addr_ff], "register written but its valid bit is clear")

endmodule
